[sv/utfd_pkg.sv]
// Shared types, constants and a helper function for the UTF-8 stream decoder.
// Used by the front end, back end and top level of the decoder; depends on nothing else.

package utfd_pkg;

   localparam int CP_W  = 21;
   localparam int OFF_W = 16;
   localparam int CNT_W = 16;
   localparam int LEN_W = 3;
   localparam int PEND_W = 2;
   localparam int PAYLOAD_W = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 21;

   localparam longint unsigned MAX_BYTES_DEFAULT = 65535;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CP_W-1:0] MAX_CP_RESET = 21'h10FFFF;
   localparam logic [CP_W-1:0] MIN_TWO_BYTE = 21'h000080;
   localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h000800;
   localparam logic [CP_W-1:0] MIN_FOUR_BYTE = 21'h010000;
   localparam logic [CP_W-1:0] SURROGATE_LO = 21'h00D800;
   localparam logic [CP_W-1:0] SURROGATE_HI = 21'h00DFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CODE_POINT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_INDEX = 1'b1;

   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_CONT,
      CLS_INVALID
   } byte_class_type;

   typedef struct packed {
      byte_class_type         cls;
      logic [PAYLOAD_W-1:0]   payload;
      logic                   last;
   } item_type;

   typedef struct packed {
      logic               char_done;
      logic [CP_W-1:0]    code_point;
      logic [OFF_W-1:0]   char_start;
      logic [CNT_W-1:0]   char_count;
      logic               error;
      logic               target_found;
      logic [OFF_W-1:0]   target_offset;
      logic               end_of_string;
   } result_type;

   function automatic logic value_ok(input logic [CP_W-1:0] v, input logic [LEN_W-1:0] len,
                                     input logic [CP_W-1:0] max_cp);
      logic [CP_W-1:0] minimum;
      logic ok;
      case (len)
         3'd2: minimum = MIN_TWO_BYTE;
         3'd3: minimum = MIN_THREE_BYTE;
         default: minimum = MIN_FOUR_BYTE;
      endcase
      ok = 1'b1;
      if (len > 3'd1 && v < minimum) ok = 1'b0;
      if (v > max_cp) ok = 1'b0;
      if (v >= SURROGATE_LO && v <= SURROGATE_HI) ok = 1'b0;
      return ok;
   endfunction

endpackage

[sv/utfd_fifo.sv]
// Small first-in first-out queue of fixed-width words with a queue-style handshake.
// Uses no package; instantiated by the decoder top level for both queues.

module utfd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[sv/utfd_front.sv]
// Front end of the decoder: classifies each incoming byte by its UTF-8 role.
// Depends on utfd_pkg for the byte class and queue item types.

module utfd_front
   import utfd_pkg::*;
(
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output item_type   item
);

   logic [7:0] b;

   assign b = req_data_byte;

   always_comb begin
      item.last = req_last;
      if (b < 8'h80) begin
         item.cls     = CLS_ASCII;
         item.payload = b[6:0];
      end else if (b < 8'hC0) begin
         item.cls     = CLS_CONT;
         item.payload = {1'b0, b[5:0]};
      end else if (b < 8'hE0) begin
         item.cls     = CLS_LEAD2;
         item.payload = {2'b00, b[4:0]};
      end else if (b < 8'hF0) begin
         item.cls     = CLS_LEAD3;
         item.payload = {3'b000, b[3:0]};
      end else if (b < 8'hF8) begin
         item.cls     = CLS_LEAD4;
         item.payload = {4'b0000, b[2:0]};
      end else begin
         item.cls     = CLS_INVALID;
         item.payload = '0;
      end
   end

endmodule

[sv/utfd_back.sv]
// Back end of the decoder: sequence state, checks, counting and target search.
// Depends on utfd_pkg; holds the configuration registers.

module utfd_back
   import utfd_pkg::*;
#(
   parameter longint unsigned MAX_BYTES = MAX_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  item_valid,
   input  item_type              item,
   output logic                  item_take,
   input  logic                  result_full,
   output logic                  result_push,
   output result_type            result
);

   localparam int POS_BITS = $clog2(MAX_BYTES + 1);
   localparam int POS_W = (POS_BITS > OFF_W) ? POS_BITS : OFF_W;

   logic [CP_W-1:0]   max_cp_ff;
   logic [CNT_W-1:0]  tidx_ff;

   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CP_W-1:0]   acc_ff, acc_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [OFF_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              err_ff, err_in;
   logic              tseen_ff, tseen_in;
   logic [OFF_W-1:0]  tpos_ff, tpos_in;
   logic              done;

   assign item_take   = item_valid && !result_full;
   assign result_push = item_take;

   always_comb begin
      pend_in  = pend_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      tseen_in = tseen_ff;
      tpos_in  = tpos_ff;
      done     = 1'b0;
      if (pos_ff >= POS_W'(MAX_BYTES)) begin
         err_in = 1'b1;
      end else begin
         pos_in = pos_ff + 1'b1;
         if (!err_ff) begin
            if (pend_ff == '0) begin
               if (!tseen_ff && cnt_ff == tidx_ff) begin
                  tseen_in = 1'b1;
                  tpos_in  = pos_ff[OFF_W-1:0];
               end
               start_in = pos_ff[OFF_W-1:0];
               case (item.cls)
                  CLS_ASCII: begin
                     len_in = 3'd1;
                     acc_in = CP_W'(item.payload);
                  end
                  CLS_LEAD2: begin
                     len_in  = 3'd2;
                     pend_in = 2'd1;
                     acc_in  = CP_W'(item.payload);
                  end
                  CLS_LEAD3: begin
                     len_in  = 3'd3;
                     pend_in = 2'd2;
                     acc_in  = CP_W'(item.payload);
                  end
                  CLS_LEAD4: begin
                     len_in  = 3'd4;
                     pend_in = 2'd3;
                     acc_in  = CP_W'(item.payload);
                  end
                  default: begin
                     err_in = 1'b1;
                  end
               endcase
            end else if (item.cls != CLS_CONT) begin
               err_in  = 1'b1;
               pend_in = '0;
            end else begin
               acc_in  = {acc_ff[CP_W-7:0], item.payload[5:0]};
               pend_in = pend_ff - 1'b1;
            end
            if (!err_in && pend_in == '0) begin
               if (value_ok(acc_in, len_in, max_cp_ff)) begin
                  done = 1'b1;
                  if (cnt_ff != '1) cnt_in = cnt_ff + 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
         end
      end
      if (item.last) begin
         if (!err_in && pend_in != '0) err_in = 1'b1;
         if (!err_in && !tseen_in && cnt_in == tidx_ff) begin
            tseen_in = 1'b1;
            tpos_in  = pos_in[OFF_W-1:0];
         end
      end
   end

   always_comb begin
      result.char_done     = done;
      result.code_point    = done ? acc_in : '0;
      result.char_start    = done ? start_in : '0;
      result.char_count    = cnt_in;
      result.error         = err_in;
      result.target_found  = tseen_in;
      result.target_offset = tseen_in ? tpos_in : '0;
      result.end_of_string = item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cp_ff <= MAX_CP_RESET;
         tidx_ff   <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_MAX_CODE_POINT) max_cp_ff <= csr_data;
         if (csr_index == CSR_TARGET_INDEX) tidx_ff <= csr_data[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         len_ff   <= '0;
         acc_ff   <= '0;
         pos_ff   <= '0;
         start_ff <= '0;
         cnt_ff   <= '0;
         err_ff   <= 1'b0;
         tseen_ff <= 1'b0;
         tpos_ff  <= '0;
      end else if (item_take) begin
         if (item.last) begin
            pend_ff  <= '0;
            len_ff   <= '0;
            acc_ff   <= '0;
            pos_ff   <= '0;
            start_ff <= '0;
            cnt_ff   <= '0;
            err_ff   <= 1'b0;
            tseen_ff <= 1'b0;
            tpos_ff  <= '0;
         end else begin
            pend_ff  <= pend_in;
            len_ff   <= len_in;
            acc_ff   <= acc_in;
            pos_ff   <= pos_in;
            start_ff <= start_in;
            cnt_ff   <= cnt_in;
            err_ff   <= err_in;
            tseen_ff <= tseen_in;
            tpos_ff  <= tpos_in;
         end
      end
   end

   a_pending_within_length: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0) |-> ({1'b0, pend_ff} < len_ff))
      else $error("pending continuation count exceeds sequence length");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff && !(item_take && item.last)) |=> err_ff)
      else $error("error flag cleared before end of string");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.last) |=> (pos_ff == '0 && cnt_ff == '0 && !err_ff && !tseen_ff))
      else $error("string state not cleared after final byte");

   a_done_without_error: assert property (@(posedge clock) disable iff (reset)
      result_push |-> !(result.char_done && result.error))
      else $error("character reported complete together with an error");

endmodule

[sv/utf8_stream_decoder_counter_unit.sv]
// UTF-8 stream decoder and character counter: takes one byte per cycle.
// A byte accepted into the item queue is decoded by the back end and its result is written
// into the result queue, from which it appears on the result ports and may be popped.
// Throughput is one byte per cycle while neither queue is full.
// Reset is synchronous: it empties both queues, clears the string state and
// restores max_code_point to 0x10FFFF and target_index to 0.

module utf8_stream_decoder_counter_unit
   import utfd_pkg::*;
#(
   parameter longint unsigned MAX_BYTES = MAX_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last,
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_char_done,
   output logic [CP_W-1:0]       rsp_code_point,
   output logic [OFF_W-1:0]      rsp_char_start,
   output logic [CNT_W-1:0]      rsp_char_count,
   output logic                  rsp_error,
   output logic                  rsp_target_found,
   output logic [OFF_W-1:0]      rsp_target_offset,
   output logic                  rsp_end_of_string,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   item_type   front_item, queued_item;
   result_type back_result, head_result;
   logic       item_empty, item_take;
   logic       result_full, result_push;

   utfd_front u_front (
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .item          (front_item)
   );

   utfd_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (full),
      .pop       (item_take),
      .pop_data  (queued_item),
      .empty     (item_empty)
   );

   utfd_back #(
      .MAX_BYTES (MAX_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .item_valid       (!item_empty),
      .item             (queued_item),
      .item_take        (item_take),
      .result_full      (result_full),
      .result_push      (result_push),
      .result           (back_result)
   );

   utfd_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (back_result),
      .full      (result_full),
      .pop       (pop),
      .pop_data  (head_result),
      .empty     (empty)
   );

   assign rsp_char_done     = head_result.char_done;
   assign rsp_code_point    = head_result.code_point;
   assign rsp_char_start    = head_result.char_start;
   assign rsp_char_count    = head_result.char_count;
   assign rsp_error         = head_result.error;
   assign rsp_target_found  = head_result.target_found;
   assign rsp_target_offset = head_result.target_offset;
   assign rsp_end_of_string = head_result.end_of_string;

endmodule
